// ===== design/aes_pkg.sv =====
package aes_pkg;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } out_beat_t;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } reg_index_t;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 64;

    // forward s-box as a constant function of the byte
    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // multiply by x modulo x^8+x^4+x^3+x+1
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== design/aes128_block_encrypt.sv =====
// channel | signals                       | handshake
// config  | cfg_we, cfg_index, cfg_data   | written when cfg_we high
// input   | start, busy, din              | beat taken when start and not busy
// output  | done, dout                    | beat shown for one cycle with done
// one block enters every cycle; each block passes through the input key-add stage
// and then the row of ten round cells, each of which is registered
// busy stays low: the pipeline never stalls and the receiver cannot stall
// reset clears the key registers and the valid bits of the row
module aes128_block_encrypt #(
    parameter int unsigned ROUNDS = aes_pkg::NUM_ROUNDS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aes_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  aes_pkg::in_beat_t                   din,
    output logic                                done,
    output aes_pkg::out_beat_t                  dout
);

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic         v0_reg;
    logic [127:0] s0_reg;
    logic [127:0] k0_reg;
    logic         v   [ROUNDS+1];
    logic [127:0] s   [ROUNDS+1];
    logic [127:0] k   [ROUNDS+1];
    logic [7:0]   rc  [ROUNDS+1];
    logic         accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (aes_pkg::reg_index_t'(cfg_index))
                aes_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aes_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // initial add round key
    always_ff @(posedge clk)
    begin
        s0_reg <= {din.plain_high, din.plain_low} ^ {key_high_reg, key_low_reg};
        k0_reg <= {key_high_reg, key_low_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    assign v[0]  = v0_reg;
    assign s[0]  = s0_reg;
    assign k[0]  = k0_reg;
    assign rc[0] = 8'h01;

    // row of round cells
    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        aes_round_cell #(
            .LAST (i == ROUNDS - 1)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (v[i]),
            .state_in  (s[i]),
            .key_in    (k[i]),
            .rcon_in   (rc[i]),
            .valid     (v[i+1]),
            .state     (s[i+1]),
            .round_key (k[i+1]),
            .rcon      (rc[i+1])
        );
    end

    assign done             = v[ROUNDS];
    assign dout.cipher_high = s[ROUNDS][127:64];
    assign dout.cipher_low  = s[ROUNDS][63:0];

    // every accepted beat must come out of the row with done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(ROUNDS+1) done)
        else $error("result beat missing");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        v[1] |-> $past(v0_reg))
        else $error("valid bit appeared without a beat");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("pipeline stalled");

endmodule

// ===== design/aes_round_cell.sv =====
// one round: key schedule step and state round, both registered
module aes_round_cell #(
    parameter bit LAST = 1'b0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         valid_in,
    input  logic [127:0] state_in,
    input  logic [127:0] key_in,
    input  logic [7:0]   rcon_in,
    output logic         valid,
    output logic [127:0] state,
    output logic [127:0] round_key,
    output logic [7:0]   rcon
);

    logic         valid_reg;
    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [127:0] key_reg;
    logic [127:0] key_next;
    logic [7:0]   rcon_reg;
    logic [7:0]   sb [16];
    logic [7:0]   sr [16];
    logic [7:0]   mc [16];
    logic [31:0]  rot_sub;
    logic [31:0]  w0, w1, w2, w3;

    // next round key from the current one
    always_comb
    begin
        rot_sub = {aes_pkg::sbox(key_in[23:16]), aes_pkg::sbox(key_in[15:8]),
                   aes_pkg::sbox(key_in[7:0]), aes_pkg::sbox(key_in[31:24])}
                  ^ {rcon_in, 24'h0};
        w0 = key_in[127:96] ^ rot_sub;
        w1 = key_in[95:64] ^ w0;
        w2 = key_in[63:32] ^ w1;
        w3 = key_in[31:0] ^ w2;
        key_next = {w0, w1, w2, w3};
    end

    // sub bytes and shift rows; byte n sits at bits 127-8n
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sb[4*c+r] = aes_pkg::sbox(state_in[127-8*(4*((c+r)%4)+r) -: 8]);
            end
        end
        sr = sb;
    end

    // mix columns, skipped in the last round, then add the round key
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            mc[4*c]   = aes_pkg::xtime(sr[4*c]) ^ aes_pkg::xtime(sr[4*c+1]) ^ sr[4*c+1]
                        ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c+1] = sr[4*c] ^ aes_pkg::xtime(sr[4*c+1]) ^ aes_pkg::xtime(sr[4*c+2])
                        ^ sr[4*c+2] ^ sr[4*c+3];
            mc[4*c+2] = sr[4*c] ^ sr[4*c+1] ^ aes_pkg::xtime(sr[4*c+2])
                        ^ aes_pkg::xtime(sr[4*c+3]) ^ sr[4*c+3];
            mc[4*c+3] = aes_pkg::xtime(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2]
                        ^ aes_pkg::xtime(sr[4*c+3]);
        end
        for (int n = 0; n < 16; n++)
        begin
            state_next[127-8*n -: 8] = (LAST ? sr[n] : mc[n]) ^ key_next[127-8*n -: 8];
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
        rcon_reg  <= aes_pkg::xtime(rcon_in);
    end

    // beat marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    assign valid     = valid_reg;
    assign state     = state_reg;
    assign round_key = key_reg;
    assign rcon      = rcon_reg;

endmodule
